// ===== hdl/wss_pkg.sv =====
package wss_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int INFO_BITS  = 48;

  localparam int MODE_W     = 3;
  localparam int PORT_SLOT_W = 4;
  localparam int PORT_INFO_W = 48;
  localparam int RANGE_W    = $clog2(SLOTS) + 2;

  localparam int WEIGHT_W   = 11;
  localparam int CLIENT_W   = 16;
  localparam int MARGIN_W   = CLIENT_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = WEIGHT_W'(1024);
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF   = WEIGHT_W'(1024 / 2);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN    = WEIGHT_W'(1);
  localparam logic [CLIENT_W-1:0] CLIENTS_MAX   = CLIENT_W'(65535);

  typedef enum logic [MODE_W-1:0] {
    MODE_CONNECT    = 3'd0,
    MODE_SUCCESS    = 3'd1,
    MODE_FAILURE    = 3'd2,
    MODE_UNCONNECT  = 3'd3,
    MODE_REGISTER   = 3'd4,
    MODE_UNREGISTER = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_SCAN_END,
    ST_CLAIM,
    ST_OUT
  } state_e;

  typedef enum logic {
    KIND_SELECT   = 1'b0,
    KIND_REGISTER = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [CLIENT_W-1:0] clients;
  } stat_t;

  localparam stat_t STAT_RESET = '{weight: WEIGHT_MAX, clients: '0};

  typedef struct packed {
    logic              en;
    logic              first;
    logic              slot_valid;
    logic [SLOT_W-1:0] idx;
  } pick_ctl_t;

endpackage

// ===== hdl/wss_ram.sv =====
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/wss_pick.sv =====
module wss_pick import wss_pkg::*; (
  input  logic                 clk_i,
  input  pick_ctl_t            ctl_i,
  input  stat_t                stat_i,
  input  logic [INFO_BITS-1:0] info_i,
  output logic [SLOT_W-1:0]    best_idx_o,
  output logic [INFO_BITS-1:0] best_info_o
);

  logic signed [MARGIN_W-1:0] margin;
  logic signed [MARGIN_W-1:0] best_margin_q;
  logic                       better;

  assign margin = $signed(MARGIN_W'(stat_i.weight)) - $signed(MARGIN_W'(stat_i.clients));
  assign better = ctl_i.slot_valid && (margin > best_margin_q);

  // Slot 0 seeds the search with its margin floored at zero, so it is the fallback answer
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.first) begin
        best_idx_o    <= ctl_i.idx;
        best_info_o   <= ctl_i.slot_valid ? info_i : '0;
        best_margin_q <= (ctl_i.slot_valid && margin > 0) ? margin : '0;
      end else if (better) begin
        best_idx_o    <= ctl_i.idx;
        best_info_o   <= info_i;
        best_margin_q <= margin;
      end
    end
  end

endmodule

// ===== hdl/weighted_server_selector.sv =====
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  mode_i, slot_i, server_info_i
// out      out_valid_o/out_ready_i result_kind_o, result_slot_o, result_info_o, table_full_o
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Connect visits one slot per cycle through the table RAM read port and the shared
// margin compare. A failure report on an in-range slot first does a read-modify-write.
// Register steps over the valid bits to the first free slot.
// Reset clears valid and written bits; unwritten stats read as weight 1024, 0 clients.
// A waiting result holds in the output register; the next item is taken meanwhile.
module weighted_server_selector import wss_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [PORT_SLOT_W-1:0] slot_i,
  input  logic [PORT_INFO_W-1:0] server_info_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   result_kind_o,
  output logic [PORT_SLOT_W-1:0] result_slot_o,
  output logic [PORT_INFO_W-1:0] result_info_o,
  output logic                   table_full_o
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [PORT_SLOT_W-1:0] slot_q, slot_d;
  logic [INFO_BITS-1:0]   info_q, info_d;
  logic [SLOT_W-1:0]      cnt_q, cnt_d;
  logic [SLOTS-1:0]       valid_q, valid_d;
  logic [SLOTS-1:0]       written_q, written_d;
  pick_ctl_t              pick_ctl_q, pick_ctl_d;
  logic                   rd_written_q, rd_written_d;

  logic                   pend_kind_q, pend_kind_d;
  logic [SLOT_W-1:0]      pend_slot_q, pend_slot_d;
  logic [INFO_BITS-1:0]   pend_info_q, pend_info_d;
  logic                   pend_full_q, pend_full_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_kind_q, out_kind_d;
  logic [PORT_SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [PORT_INFO_W-1:0] out_info_q, out_info_d;
  logic                   out_full_q, out_full_d;

  logic                 stat_we;
  stat_t                stat_wdata, stat_rdata, stat_eff;
  logic [SLOT_W-1:0]    stat_raddr;
  logic                 info_we;
  logic [INFO_BITS-1:0] info_rdata;
  logic [SLOT_W-1:0]    best_idx;
  logic [INFO_BITS-1:0] best_info;

  logic              in_range, in_range_q;
  logic [SLOT_W-1:0] in_idx, slot_idx;
  logic              cnt_last;

  assign in_range   = RANGE_W'(slot_i) < RANGE_W'(SLOTS);
  assign in_range_q = RANGE_W'(slot_q) < RANGE_W'(SLOTS);
  assign in_idx     = SLOT_W'(slot_i);
  assign slot_idx   = SLOT_W'(slot_q);
  assign cnt_last   = (cnt_q == SLOT_W'(SLOTS - 1));
  assign stat_eff   = rd_written_q ? stat_rdata : STAT_RESET;

  wss_ram #(.WIDTH($bits(stat_t)), .DEPTH(SLOTS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (slot_idx),
    .wdata_i (stat_wdata),
    .raddr_i (stat_raddr),
    .rdata_o (stat_rdata)
  );

  wss_ram #(.WIDTH(INFO_BITS), .DEPTH(SLOTS)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (cnt_q),
    .wdata_i (info_q),
    .raddr_i (cnt_q),
    .rdata_o (info_rdata)
  );

  wss_pick u_pick (
    .clk_i       (clk_i),
    .ctl_i       (pick_ctl_q),
    .stat_i      (stat_eff),
    .info_i      (info_rdata),
    .best_idx_o  (best_idx),
    .best_info_o (best_info)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    slot_d      = slot_q;
    info_d      = info_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    written_d   = written_q;
    pend_kind_d = pend_kind_q;
    pend_slot_d = pend_slot_q;
    pend_info_d = pend_info_q;
    pend_full_d = pend_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_info_d  = out_info_q;
    out_full_d  = out_full_q;
    in_ready_o  = 1'b0;
    stat_we     = 1'b0;
    stat_wdata  = stat_eff;
    stat_raddr  = cnt_q;
    info_we     = 1'b0;

    pick_ctl_d.en         = 1'b0;
    pick_ctl_d.first      = (cnt_q == '0);
    pick_ctl_d.slot_valid = valid_q[cnt_q];
    pick_ctl_d.idx        = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          mode_d = mode_e'(mode_i);
          slot_d = slot_i;
          info_d = INFO_BITS'(server_info_i);
          unique case (mode_e'(mode_i))
            MODE_CONNECT: state_d = ST_SCAN;
            MODE_SUCCESS, MODE_UNCONNECT: state_d = in_range ? ST_READ : ST_IDLE;
            MODE_FAILURE: state_d = in_range ? ST_READ : ST_SCAN;
            MODE_REGISTER: state_d = ST_CLAIM;
            MODE_UNREGISTER: begin
              // Dropping the written bit restores the reset weight and count
              if (in_range) begin
                valid_d[in_idx]   = 1'b0;
                written_d[in_idx] = 1'b0;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_READ: begin
        stat_raddr = slot_idx;
        state_d    = ST_MODIFY;
      end

      ST_MODIFY: begin
        stat_we             = in_range_q;
        written_d[slot_idx] = 1'b1;
        unique case (mode_q)
          MODE_SUCCESS: begin
            if (stat_eff.weight <= WEIGHT_HALF) begin
              stat_wdata.weight = {stat_eff.weight[WEIGHT_W-2:0], 1'b0};
            end
            if (stat_eff.clients != CLIENTS_MAX) begin
              stat_wdata.clients = stat_eff.clients + CLIENT_W'(1);
            end
          end
          MODE_FAILURE: begin
            if (stat_eff.weight > WEIGHT_MIN) begin
              stat_wdata.weight = stat_eff.weight >> 1;
            end
          end
          MODE_UNCONNECT: begin
            if (stat_eff.clients != '0) begin
              stat_wdata.clients = stat_eff.clients - CLIENT_W'(1);
            end
          end
          default: stat_wdata = stat_eff;
        endcase
        state_d = (mode_q == MODE_FAILURE) ? ST_SCAN : ST_IDLE;
      end

      ST_SCAN: begin
        pick_ctl_d.en = 1'b1;
        if (cnt_last) begin
          state_d = ST_SCAN_END;
        end else begin
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end

      ST_SCAN_END: begin
        // Last compare lands at this edge; the answer is taken from the pick unit
        pend_kind_d = KIND_SELECT;
        pend_full_d = 1'b0;
        state_d     = ST_OUT;
      end

      ST_CLAIM: begin
        if (!valid_q[cnt_q]) begin
          info_we        = 1'b1;
          valid_d[cnt_q] = 1'b1;
          pend_kind_d    = KIND_REGISTER;
          pend_slot_d    = cnt_q;
          pend_info_d    = info_q;
          pend_full_d    = 1'b0;
          state_d        = ST_OUT;
        end else if (cnt_last) begin
          pend_kind_d = KIND_REGISTER;
          pend_slot_d = '0;
          pend_info_d = '0;
          pend_full_d = 1'b1;
          state_d     = ST_OUT;
        end else begin
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_kind_d  = pend_kind_q;
          out_full_d  = pend_full_q;
          if (pend_kind_q == KIND_SELECT) begin
            out_slot_d = PORT_SLOT_W'(best_idx);
            out_info_d = PORT_INFO_W'(best_info);
          end else begin
            out_slot_d = PORT_SLOT_W'(pend_slot_q);
            out_info_d = PORT_INFO_W'(pend_info_q);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    rd_written_d = written_q[stat_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      written_q   <= '0;
      pick_ctl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      written_q   <= written_d;
      pick_ctl_q  <= pick_ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    slot_q       <= slot_d;
    info_q       <= info_d;
    rd_written_q <= rd_written_d;
    pend_kind_q  <= pend_kind_d;
    pend_slot_q  <= pend_slot_d;
    pend_info_q  <= pend_info_d;
    pend_full_q  <= pend_full_d;
    out_kind_q   <= out_kind_d;
    out_slot_q   <= out_slot_d;
    out_info_q   <= out_info_d;
    out_full_q   <= out_full_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign result_slot_o = out_slot_q;
  assign result_info_o = out_info_q;
  assign table_full_o  = out_full_q;

`ifndef ASSERT_OFF
  a_weight_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_we |-> (stat_wdata.weight != '0 && stat_wdata.weight <= WEIGHT_MAX))
    else $error("weight written outside its bounds");

  a_claim_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAIM && !valid_q[cnt_q]) |=> valid_q[$past(cnt_q)])
    else $error("claimed slot not marked valid");

  a_idle_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pick_ctl_q.en)
    else $error("compare still in flight while idle");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result not loaded into output register");
`endif

endmodule
